// ===== rtl/core/lav_pkg.sv =====
`default_nettype none
package lav_pkg;

    localparam int WORD_W     = 32;
    localparam int ACC_W      = 66;
    localparam int SCALE_MSB  = 29;
    localparam int SQRT_STEPS = 32;
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } norm_stat_t;

    // Round half away from zero, then shift right by s.
    function automatic acc_t round_shift(input acc_t v, input int s);
        acc_t half;
        acc_t rnd;
        half = acc_t'(1) << (s - 1);
        rnd  = v[ACC_W-1] ? half - acc_t'(1) : half;
        return (v + rnd) >>> s;
    endfunction

    function automatic word_t sat_word(input acc_t v);
        word_t r;
        if (&v[ACC_W-1:WORD_W-1] || ~|v[ACC_W-1:WORD_W-1]) begin
            r = v[WORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/look_at_view_matrix.sv =====
`default_nettype none
// Throughput: the four-row output serializer sends each matrix as four rows; the
// pipeline behind it takes an item every cycle while the serializer has room.
// Each normalizer holds a 32-stage square root and a FRAC_BITS+1 stage divider.
// Reset (aresetn low, synchronous) clears all valid bits, output valid and row index; data regs hold.
module look_at_view_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // row_index[1:0], col0[33:2], col1[65:34], col2[97:66], col3[129:98], zero pad
    output logic [135:0]      m_tdata,
    output logic              m_tlast,
    // degenerate
    output logic [0:0]        m_tuser
);

    localparam lav_pkg::word_t ONE = lav_pkg::word_t'(64'd1 << FRAC_BITS);

    logic en;
    logic ser_free;

    // input stage
    logic                a_v_reg;
    lav_pkg::word_t      eye_a_reg [3];
    lav_pkg::word_t      up_a_reg  [3];
    logic signed [32:0]  d_a_reg   [3];
    logic [32:0]         d_mag     [3];
    logic [2:0]          d_neg;

    lav_pkg::norm_stat_t st1;
    lav_pkg::word_t      za1 [3];
    logic [191:0]        side1;
    lav_pkg::word_t      eye1 [3];
    lav_pkg::word_t      up1  [3];

    logic                b_v_reg, c_v_reg;
    logic signed [63:0]  pb_reg [6];
    lav_pkg::word_t      za_b_reg [3], eye_b_reg [3];
    logic                z_b_reg;
    logic signed [63:0]  c_reg [3];
    lav_pkg::word_t      za_c_reg [3], eye_c_reg [3];
    logic                z_c_reg;
    logic [62:0]         c_mag [3];
    logic [2:0]          c_neg;

    lav_pkg::norm_stat_t st2;
    lav_pkg::word_t      xa2 [3];
    logic [192:0]        side2;
    lav_pkg::word_t      za2 [3];
    lav_pkg::word_t      eye2 [3];

    logic                d_v_reg, e_v_reg, f_v_reg, g_v_reg, h_v_reg, i_v_reg, j_v_reg;
    logic signed [63:0]  yp_d_reg [6], xe_d_reg [3], ze_d_reg [3];
    lav_pkg::word_t      xa_d_reg [3], za_d_reg [3], eye_d_reg [3];
    logic                dg_d_reg;
    logic signed [63:0]  ys_e_reg [3];
    lav_pkg::acc_t       dx_e_reg, dz_e_reg;
    lav_pkg::word_t      xa_e_reg [3], za_e_reg [3], eye_e_reg [3];
    logic                dg_e_reg;
    lav_pkg::word_t      ya_f_reg [3], xa_f_reg [3], za_f_reg [3], eye_f_reg [3];
    lav_pkg::acc_t       tx_f_reg, tz_f_reg;
    logic                dg_f_reg;
    logic signed [63:0]  ye_g_reg [3];
    lav_pkg::word_t      ya_g_reg [3], xa_g_reg [3], za_g_reg [3];
    lav_pkg::word_t      tx_g_reg, tz_g_reg;
    logic                dg_g_reg;
    lav_pkg::acc_t       dy_h_reg;
    lav_pkg::word_t      ya_h_reg [3], xa_h_reg [3], za_h_reg [3];
    lav_pkg::word_t      tx_h_reg, tz_h_reg;
    logic                dg_h_reg;
    lav_pkg::acc_t       ty_i_reg;
    lav_pkg::word_t      ya_i_reg [3], xa_i_reg [3], za_i_reg [3];
    lav_pkg::word_t      tx_i_reg, tz_i_reg;
    logic                dg_i_reg;
    lav_pkg::word_t      ya_j_reg [3], xa_j_reg [3], za_j_reg [3], tr_j_reg [3];
    logic                dg_j_reg;

    // output serializer
    logic                ov_reg;
    logic [1:0]          row_reg;
    lav_pkg::word_t      xs_reg [3], ys_reg [3], zs_reg [3], ts_reg [3];
    logic                dg_reg;
    lav_pkg::word_t      col0, col1, col2, col3;

    assign ser_free = !ov_reg || (m_tready && row_reg == lav_pkg::ROW_LAST);
    assign en       = !j_v_reg || ser_free;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                eye_a_reg[i] <= s_tdata[32*i +: 32];
                up_a_reg[i]  <= s_tdata[192 + 32*i +: 32];
                d_a_reg[i]   <= 33'(lav_pkg::word_t'(s_tdata[96 + 32*i +: 32]))
                                - 33'(lav_pkg::word_t'(s_tdata[32*i +: 32]));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_neg[i] = d_a_reg[i][32];
            d_mag[i] = d_a_reg[i][32] ? 33'(-d_a_reg[i]) : 33'(d_a_reg[i]);
            c_neg[i] = c_reg[i][63];
            c_mag[i] = c_reg[i][63] ? 63'(-c_reg[i]) : 63'(c_reg[i]);
        end
    end

    lav_norm #(.IW(33), .FRAC_BITS(FRAC_BITS), .SW(192)) u_norm_fwd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_v_reg),
        .in_mag   (d_mag),
        .in_neg   (d_neg),
        .in_side  ({up_a_reg[2], up_a_reg[1], up_a_reg[0],
                    eye_a_reg[2], eye_a_reg[1], eye_a_reg[0]}),
        .out_stat (st1),
        .out_unit (za1),
        .out_side (side1)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            eye1[i] = side1[32*i +: 32];
            up1[i]  = side1[96 + 32*i +: 32];
            eye2[i] = side2[32*i +: 32];
            za2[i]  = side2[96 + 32*i +: 32];
        end
    end

    // side axis: cross(up, z)
    always_ff @(posedge aclk) begin
        if (en) begin
            pb_reg[0] <= 64'(up1[1]) * 64'(za1[2]);
            pb_reg[1] <= 64'(up1[2]) * 64'(za1[1]);
            pb_reg[2] <= 64'(up1[2]) * 64'(za1[0]);
            pb_reg[3] <= 64'(up1[0]) * 64'(za1[2]);
            pb_reg[4] <= 64'(up1[0]) * 64'(za1[1]);
            pb_reg[5] <= 64'(up1[1]) * 64'(za1[0]);
            za_b_reg  <= za1;
            eye_b_reg <= eye1;
            z_b_reg   <= st1.zero;
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= pb_reg[2*i] - pb_reg[2*i+1];
            end
            za_c_reg  <= za_b_reg;
            eye_c_reg <= eye_b_reg;
            z_c_reg   <= z_b_reg;
        end
    end

    lav_norm #(.IW(63), .FRAC_BITS(FRAC_BITS), .SW(193)) u_norm_side (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (c_v_reg),
        .in_mag   (c_mag),
        .in_neg   (c_neg),
        .in_side  ({z_c_reg, za_c_reg[2], za_c_reg[1], za_c_reg[0],
                    eye_c_reg[2], eye_c_reg[1], eye_c_reg[0]}),
        .out_stat (st2),
        .out_unit (xa2),
        .out_side (side2)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            // true up axis cross(z, x), and the dots with the eye
            yp_d_reg[0] <= 64'(za2[1]) * 64'(xa2[2]);
            yp_d_reg[1] <= 64'(za2[2]) * 64'(xa2[1]);
            yp_d_reg[2] <= 64'(za2[2]) * 64'(xa2[0]);
            yp_d_reg[3] <= 64'(za2[0]) * 64'(xa2[2]);
            yp_d_reg[4] <= 64'(za2[0]) * 64'(xa2[1]);
            yp_d_reg[5] <= 64'(za2[1]) * 64'(xa2[0]);
            for (int i = 0; i < 3; i++) begin
                xe_d_reg[i] <= 64'(xa2[i]) * 64'(eye2[i]);
                ze_d_reg[i] <= 64'(za2[i]) * 64'(eye2[i]);
            end
            xa_d_reg  <= xa2;
            za_d_reg  <= za2;
            eye_d_reg <= eye2;
            dg_d_reg  <= side2[192] | st2.zero;

            for (int i = 0; i < 3; i++) begin
                ys_e_reg[i] <= yp_d_reg[2*i] - yp_d_reg[2*i+1];
            end
            dx_e_reg  <= lav_pkg::acc_t'(xe_d_reg[0]) + lav_pkg::acc_t'(xe_d_reg[1])
                         + lav_pkg::acc_t'(xe_d_reg[2]);
            dz_e_reg  <= lav_pkg::acc_t'(ze_d_reg[0]) + lav_pkg::acc_t'(ze_d_reg[1])
                         + lav_pkg::acc_t'(ze_d_reg[2]);
            xa_e_reg  <= xa_d_reg;
            za_e_reg  <= za_d_reg;
            eye_e_reg <= eye_d_reg;
            dg_e_reg  <= dg_d_reg;

            for (int i = 0; i < 3; i++) begin
                ya_f_reg[i] <= lav_pkg::sat_word(
                    lav_pkg::round_shift(lav_pkg::acc_t'(ys_e_reg[i]), FRAC_BITS));
            end
            tx_f_reg  <= lav_pkg::round_shift(dx_e_reg, FRAC_BITS);
            tz_f_reg  <= lav_pkg::round_shift(dz_e_reg, FRAC_BITS);
            xa_f_reg  <= xa_e_reg;
            za_f_reg  <= za_e_reg;
            eye_f_reg <= eye_e_reg;
            dg_f_reg  <= dg_e_reg;

            for (int i = 0; i < 3; i++) begin
                ye_g_reg[i] <= 64'(ya_f_reg[i]) * 64'(eye_f_reg[i]);
            end
            tx_g_reg <= lav_pkg::sat_word(-tx_f_reg);
            tz_g_reg <= lav_pkg::sat_word(-tz_f_reg);
            ya_g_reg <= ya_f_reg;
            xa_g_reg <= xa_f_reg;
            za_g_reg <= za_f_reg;
            dg_g_reg <= dg_f_reg;

            dy_h_reg <= lav_pkg::acc_t'(ye_g_reg[0]) + lav_pkg::acc_t'(ye_g_reg[1])
                        + lav_pkg::acc_t'(ye_g_reg[2]);
            ya_h_reg <= ya_g_reg;
            xa_h_reg <= xa_g_reg;
            za_h_reg <= za_g_reg;
            tx_h_reg <= tx_g_reg;
            tz_h_reg <= tz_g_reg;
            dg_h_reg <= dg_g_reg;

            ty_i_reg <= lav_pkg::round_shift(dy_h_reg, FRAC_BITS);
            ya_i_reg <= ya_h_reg;
            xa_i_reg <= xa_h_reg;
            za_i_reg <= za_h_reg;
            tx_i_reg <= tx_h_reg;
            tz_i_reg <= tz_h_reg;
            dg_i_reg <= dg_h_reg;

            tr_j_reg[0] <= tx_i_reg;
            tr_j_reg[1] <= lav_pkg::sat_word(-ty_i_reg);
            tr_j_reg[2] <= tz_i_reg;
            ya_j_reg    <= ya_i_reg;
            xa_j_reg    <= xa_i_reg;
            za_j_reg    <= za_i_reg;
            dg_j_reg    <= dg_i_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
            j_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_tvalid;
            b_v_reg <= st1.valid;
            c_v_reg <= b_v_reg;
            d_v_reg <= st2.valid;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
            j_v_reg <= i_v_reg;
        end
    end

    // Hold one matrix and hand it out a row per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg  <= 1'b0;
            row_reg <= '0;
        end else if (j_v_reg && ser_free) begin
            ov_reg  <= 1'b1;
            row_reg <= '0;
        end else if (ov_reg && m_tready) begin
            if (row_reg == lav_pkg::ROW_LAST) begin
                ov_reg <= 1'b0;
            end
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (j_v_reg && ser_free) begin
            xs_reg <= xa_j_reg;
            ys_reg <= ya_j_reg;
            zs_reg <= za_j_reg;
            ts_reg <= tr_j_reg;
            dg_reg <= dg_j_reg;
        end
    end

    always_comb begin
        if (row_reg == lav_pkg::ROW_LAST) begin
            col0 = ts_reg[0];
            col1 = ts_reg[1];
            col2 = ts_reg[2];
            col3 = ONE;
        end else begin
            col0 = xs_reg[row_reg];
            col1 = ys_reg[row_reg];
            col2 = zs_reg[row_reg];
            col3 = '0;
        end
    end

    assign m_tvalid   = ov_reg;
    assign m_tdata    = {6'd0, col3, col2, col1, col0, row_reg};
    assign m_tlast    = (row_reg == lav_pkg::ROW_LAST);
    assign m_tuser[0] = dg_reg;

endmodule
`default_nettype wire

// ===== rtl/core/lav_norm.sv =====
`default_nettype none
module lav_norm #(
    parameter int IW        = 33,
    parameter int FRAC_BITS = 16,
    parameter int SW        = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [IW-1:0]        in_mag [3],
    input  wire logic [2:0]           in_neg,
    input  wire logic [SW-1:0]        in_side,
    output lav_pkg::norm_stat_t       out_stat,
    output lav_pkg::word_t            out_unit [3],
    output logic [SW-1:0]             out_side
);

    localparam int PW      = $clog2(IW);
    localparam int SMW     = lav_pkg::SCALE_MSB + 1;
    localparam int SQ      = lav_pkg::SQRT_STEPS;
    localparam int DQ      = FRAC_BITS + 1;
    localparam int RW      = 32 + FRAC_BITS;
    localparam int S_SQ0   = 5;
    localparam int S_PREP  = S_SQ0 + SQ;
    localparam int S_DIV0  = S_PREP + 1;
    localparam int S_OUT   = S_DIV0 + DQ;
    localparam int NS      = S_OUT + 1;

    logic [NS-1:0]    v_reg;
    logic [2:0]       neg_reg  [NS];
    logic             zero_reg [NS];
    logic [SW-1:0]    side_reg [NS];

    logic [IW-1:0]    m0_reg [3];
    logic [IW-1:0]    m1_reg [3];
    logic [PW-1:0]    pos1_reg;
    logic [SMW-1:0]   sm_reg [2:S_PREP-1][3];
    logic [2*SMW-1:0] sq3_reg [3];
    logic [63:0]      sqx_reg [4:S_PREP-1];
    logic [63:0]      sqr_reg [4:S_PREP-1];
    logic [RW-1:0]    rem_reg [S_PREP:S_OUT-1][3];
    logic [DQ-1:0]    q_reg   [S_PREP:S_OUT-1][3];
    logic [31:0]      dvs_reg [S_PREP:S_OUT-1];
    lav_pkg::word_t   unit_reg [3];

    logic [IW-1:0]    mx;
    logic [PW-1:0]    pos;
    logic [SMW-1:0]   sm_next [3];

    // One digit of the bitwise integer square root.
    function automatic logic [127:0] sqrt_step(input logic [63:0] x, input logic [63:0] r,
                                               input int sh);
        logic [63:0] b;
        logic [63:0] t;
        b = 64'd1 << sh;
        t = r + b;
        if (x >= t) begin
            return {x - t, (r >> 1) + b};
        end
        return {x, r >> 1};
    endfunction

    always_comb begin
        mx = m0_reg[0];
        if (m0_reg[1] > mx) mx = m0_reg[1];
        if (m0_reg[2] > mx) mx = m0_reg[2];
        pos = '0;
        for (int b = 0; b < IW; b++) begin
            if (mx[b]) pos = PW'(b);
        end
    end

    // Scale so the largest magnitude has its top bit at SCALE_MSB.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (pos1_reg > PW'(lav_pkg::SCALE_MSB)) begin
                sm_next[i] = SMW'(m1_reg[i] >> (pos1_reg - PW'(lav_pkg::SCALE_MSB)));
            end else begin
                sm_next[i] = SMW'(m1_reg[i] << (PW'(lav_pkg::SCALE_MSB) - pos1_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg[0]  <= in_neg;
            zero_reg[0] <= ~|{in_mag[0], in_mag[1], in_mag[2]};
            side_reg[0] <= in_side;
            for (int k = 1; k < NS; k++) begin
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end

            m0_reg   <= in_mag;
            m1_reg   <= m0_reg;
            pos1_reg <= pos;
            sm_reg[2] <= sm_next;
            for (int k = 3; k < S_PREP; k++) begin
                sm_reg[k] <= sm_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                sq3_reg[i] <= (2*SMW)'(sm_reg[2][i]) * (2*SMW)'(sm_reg[2][i]);
            end
            sqx_reg[4] <= 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);
            sqr_reg[4] <= '0;
            for (int k = S_SQ0; k < S_PREP; k++) begin
                {sqx_reg[k], sqr_reg[k]} <= sqrt_step(sqx_reg[k-1], sqr_reg[k-1],
                                                      2 * (SQ - 1 - (k - S_SQ0)));
            end

            dvs_reg[S_PREP] <= sqr_reg[S_PREP-1][31:0];
            for (int i = 0; i < 3; i++) begin
                rem_reg[S_PREP][i] <= ({RW'(sm_reg[S_PREP-1][i])} << FRAC_BITS)
                                      + RW'(sqr_reg[S_PREP-1][31:1]);
                q_reg[S_PREP][i]   <= '0;
            end
            // Restoring division, one quotient bit per stage, MSB first.
            for (int k = S_DIV0; k < S_OUT; k++) begin
                dvs_reg[k] <= dvs_reg[k-1];
                for (int i = 0; i < 3; i++) begin
                    if (rem_reg[k-1][i] >= (RW'(dvs_reg[k-1]) << (FRAC_BITS - (k - S_DIV0))))
                    begin
                        rem_reg[k][i] <= rem_reg[k-1][i]
                                         - (RW'(dvs_reg[k-1]) << (FRAC_BITS - (k - S_DIV0)));
                        q_reg[k][i]   <= q_reg[k-1][i]
                                         | (DQ'(1) << (FRAC_BITS - (k - S_DIV0)));
                    end else begin
                        rem_reg[k][i] <= rem_reg[k-1][i];
                        q_reg[k][i]   <= q_reg[k-1][i];
                    end
                end
            end

            for (int i = 0; i < 3; i++) begin
                if (zero_reg[S_OUT-1]) begin
                    unit_reg[i] <= '0;
                end else if (neg_reg[S_OUT-1][i]) begin
                    unit_reg[i] <= -lav_pkg::word_t'(q_reg[S_OUT-1][i]);
                end else begin
                    unit_reg[i] <= lav_pkg::word_t'(q_reg[S_OUT-1][i]);
                end
            end
        end
    end

    assign out_stat.valid = v_reg[NS-1];
    assign out_stat.zero  = zero_reg[NS-1];
    assign out_unit       = unit_reg;
    assign out_side       = side_reg[NS-1];

endmodule
`default_nettype wire

// ===== rtl/core/lav_checker.sv =====
`default_nettype none
module lav_checker #(
    parameter int FRAC_BITS = 16
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [135:0] m_tdata,
    input wire logic         m_tlast,
    input wire logic [0:0]   m_tuser
);

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    // last mark sits on the fourth row only
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == lav_pkg::ROW_LAST)))
        else $error("tlast does not match row index");

    // rows of one matrix come back to back in order
    a_row_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1))
        else $error("row sequence broken");

    // degenerate flag is the same on every row of a matrix
    a_degen_const: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tuser == $past(m_tuser)))
        else $error("degenerate flag changed inside a matrix");

    a_col3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast ? (m_tdata[129:98] == ONE) : (m_tdata[129:98] == 32'd0)))
        else $error("fourth column wrong");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled item changed");

endmodule

bind look_at_view_matrix lav_checker #(.FRAC_BITS(FRAC_BITS)) u_lav_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
